>>> rtl/dap_pkg.sv
// Shared constants and codes for the antialiased disc alpha pipeline.
package dap_pkg;

  localparam int LOG2_MAX_SIZE_DEF     = 9;
  localparam int DIST_FRAC_BITS_DEF    = 8;
  localparam int SQRT_STEPS_PER_STAGE  = 4;
  localparam int ALPHA_W               = 8;
  localparam int DIV_STAGES            = 2;
  localparam int DIV_STEPS             = ALPHA_W / DIV_STAGES;
  localparam int RF_W                  = 16;
  localparam logic [RF_W-1:0] RADIUS_FRACTION_RESET = 16'd55706;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd255;
  localparam logic [ALPHA_W-1:0] ALPHA_NONE = 8'd0;

  typedef enum logic [1:0] {
    ZONE_OUT   = 2'd0,
    ZONE_FULL  = 2'd1,
    ZONE_RIM   = 2'd2,
    ZONE_SMALL = 2'd3
  } zone_t;

endpackage

>>> rtl/dap_front.sv
// Front stage: level clamp, coordinate wrap, squared distance and radius.
module dap_front #(
  parameter int LOG2_MAX_SIZE  = dap_pkg::LOG2_MAX_SIZE_DEF,
  parameter int DIST_FRAC_BITS = dap_pkg::DIST_FRAC_BITS_DEF,
  parameter int RAD_W          = 2 * (LOG2_MAX_SIZE + DIST_FRAC_BITS + 2),
  parameter int RADIUS_W       = LOG2_MAX_SIZE + DIST_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [8:0]               in_pixel_x,
  input  logic [8:0]               in_pixel_y,
  input  logic [3:0]               in_size_level,
  input  logic [dap_pkg::RF_W-1:0] radius_fraction,
  output logic                     valid_r,
  output logic [RAD_W-1:0]         radicand_r,
  output logic [RADIUS_W-1:0]      radius_r
);

  localparam int EW    = LOG2_MAX_SIZE + 11;
  localparam int OFF_W = LOG2_MAX_SIZE + 1;
  localparam int SUM_W = 2 * OFF_W + 1;
  localparam int PR_W  = dap_pkg::RF_W + LOG2_MAX_SIZE;
  localparam logic [3:0] LVL_MAX = 4'(LOG2_MAX_SIZE);

  logic [3:0]          lvl;
  logic [EW-1:0]       size;
  logic [EW-1:0]       cx;
  logic [EW-1:0]       cy;
  logic [EW-1:0]       tx;
  logic [EW-1:0]       ty;
  logic [OFF_W-1:0]    dx;
  logic [OFF_W-1:0]    dy;
  logic [SUM_W-1:0]    sum;
  logic [PR_W-1:0]     scaled;
  logic [RAD_W-1:0]    radicand_nxt;
  logic [RADIUS_W-1:0] radius_nxt;

  always_comb begin
    lvl  = (in_size_level > LVL_MAX) ? LVL_MAX : in_size_level;
    size = EW'(1) << lvl;
    cx   = EW'(in_pixel_x) & (size - EW'(1));
    cy   = EW'(in_pixel_y) & (size - EW'(1));
    tx   = (cx << 1) + EW'(1);
    ty   = (cy << 1) + EW'(1);
    dx   = OFF_W'((tx >= size) ? (tx - size) : (size - tx));
    dy   = OFF_W'((ty >= size) ? (ty - size) : (size - ty));
    sum  = SUM_W'(dx * dx) + SUM_W'(dy * dy);
    radicand_nxt = RAD_W'(sum) << (2 * DIST_FRAC_BITS);
    scaled = PR_W'(radius_fraction) << lvl;
    radius_nxt = RADIUS_W'(scaled >> (17 - DIST_FRAC_BITS))
               + (RADIUS_W'(1) << (DIST_FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radicand_r <= radicand_nxt;
      radius_r   <= radius_nxt;
    end
  end

endmodule

>>> rtl/dap_sqrt_stage.sv
// Square root stage: a few digit-by-digit root steps, two radicand bits each.
module dap_sqrt_stage #(
  parameter int ROOT_W = 19,
  parameter int STEPS  = 4,
  parameter int SIDE_W = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_rad,
  input  logic [ROOT_W+1:0]   in_rem,
  input  logic [ROOT_W-1:0]   in_root,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                valid_r,
  output logic [2*ROOT_W-1:0] rad_r,
  output logic [ROOT_W+1:0]   rem_r,
  output logic [ROOT_W-1:0]   root_r,
  output logic [SIDE_W-1:0]   side_r
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_nxt;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  always_comb begin
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    rad_nxt  = in_rad;
    rem_nxt  = in_rem;
    root_nxt = in_root;
    for (int i = 0; i < STEPS; i++) begin
      sh    = {rem_nxt[REM_W-3:0], rad_nxt[RAD_W-1:RAD_W-2]};
      trial = {root_nxt, 2'b01};
      rad_nxt = rad_nxt << 2;
      if (sh >= trial) begin
        rem_nxt  = sh - trial;
        root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = sh;
        root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

endmodule

>>> rtl/dap_div_stage.sv
// Divider stage: restoring long-division steps for the small-disc alpha.
module dap_div_stage #(
  parameter int DV_W   = 8,
  parameter int STEPS  = 4,
  parameter int SIDE_W = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [DV_W-1:0]             in_rem,
  input  logic [dap_pkg::ALPHA_W-1:0] in_low,
  input  logic [dap_pkg::ALPHA_W-1:0] in_quot,
  input  logic [DV_W-1:0]             in_dvs,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        valid_r,
  output logic [DV_W-1:0]             rem_r,
  output logic [dap_pkg::ALPHA_W-1:0] low_r,
  output logic [dap_pkg::ALPHA_W-1:0] quot_r,
  output logic [DV_W-1:0]             dvs_r,
  output logic [SIDE_W-1:0]           side_r
);

  localparam int AW = dap_pkg::ALPHA_W;

  logic [DV_W-1:0] rem_nxt;
  logic [AW-1:0]   low_nxt;
  logic [AW-1:0]   quot_nxt;

  always_comb begin
    logic [DV_W:0] t;
    rem_nxt  = in_rem;
    low_nxt  = in_low;
    quot_nxt = in_quot;
    for (int i = 0; i < STEPS; i++) begin
      t       = {rem_nxt, low_nxt[AW-1]};
      low_nxt = low_nxt << 1;
      if (t >= {1'b0, in_dvs}) begin
        rem_nxt  = DV_W'(t - {1'b0, in_dvs});
        quot_nxt = {quot_nxt[AW-2:0], 1'b1};
      end else begin
        rem_nxt  = t[DV_W-1:0];
        quot_nxt = {quot_nxt[AW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      quot_r <= quot_nxt;
      dvs_r  <= in_dvs;
      side_r <= in_side;
    end
  end

endmodule

>>> rtl/antialiased_disc_alpha.sv
// Top level: antialiased disc coverage alpha, one pixel per cycle while not stalled.
//
//   channel | direction | ports                                    | transfer
//   in      | input     | in_pixel_x, in_pixel_y, in_size_level    | in_valid & !in_stall
//   out     | output    | out_alpha                                | out_valid & !out_stall
//   cfg     | input     | cfg_wr_data (radius_fraction)            | cfg_wr_en
//
// One pixel enters per cycle while in_stall is low; the registers are the front stage, the square root
// stages at up to four root bits each, the alpha register, the divider stages and the output register.
// Reset clears all valid bits and loads radius_fraction with its default.
// A stalled output freezes every stage together; in_stall follows out_stall
// while the output register holds a result.
module antialiased_disc_alpha #(
  parameter int LOG2_MAX_SIZE  = dap_pkg::LOG2_MAX_SIZE_DEF,
  parameter int DIST_FRAC_BITS = dap_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [8:0]                  in_pixel_x,
  input  logic [8:0]                  in_pixel_y,
  input  logic [3:0]                  in_size_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dap_pkg::ALPHA_W-1:0] out_alpha,
  input  logic                        cfg_wr_en,
  input  logic [dap_pkg::RF_W-1:0]    cfg_wr_data
);

  localparam int F        = DIST_FRAC_BITS;
  localparam int AW       = dap_pkg::ALPHA_W;
  localparam int RW       = LOG2_MAX_SIZE + F + 2;
  localparam int RAD_W    = 2 * RW;
  localparam int REM_W    = RW + 2;
  localparam int RADIUS_W = LOG2_MAX_SIZE + F;
  localparam int SPS      = dap_pkg::SQRT_STEPS_PER_STAGE;
  localparam int N_SQ     = (RW + SPS - 1) / SPS;
  localparam int SIDE_W   = 2 + AW;

  logic                   adv;
  logic [dap_pkg::RF_W-1:0] radius_fraction_r;

  logic                   fr_valid;
  logic [RAD_W-1:0]       fr_rad;
  logic [RADIUS_W-1:0]    fr_radius;

  logic                   sq_valid [N_SQ+1];
  logic [RAD_W-1:0]       sq_rad   [N_SQ+1];
  logic [REM_W-1:0]       sq_rem   [N_SQ+1];
  logic [RW-1:0]          sq_root  [N_SQ+1];
  logic [RADIUS_W-1:0]    sq_side  [N_SQ+1];

  logic                   a_valid_r;
  logic [F-1:0]           a_rem_r;
  logic [AW-1:0]          a_low_r;
  logic [F-1:0]           a_dvs_r;
  logic [SIDE_W-1:0]      a_side_r;
  logic [F-1:0]           a_rem_nxt;
  logic [AW-1:0]          a_low_nxt;
  logic [F-1:0]           a_dvs_nxt;
  logic [SIDE_W-1:0]      a_side_nxt;

  logic                   dv_valid [dap_pkg::DIV_STAGES+1];
  logic [F-1:0]           dv_rem   [dap_pkg::DIV_STAGES+1];
  logic [AW-1:0]          dv_low   [dap_pkg::DIV_STAGES+1];
  logic [AW-1:0]          dv_quot  [dap_pkg::DIV_STAGES+1];
  logic [F-1:0]           dv_dvs   [dap_pkg::DIV_STAGES+1];
  logic [SIDE_W-1:0]      dv_side  [dap_pkg::DIV_STAGES+1];

  logic                   out_valid_r;
  logic [AW-1:0]          out_alpha_r;
  logic [AW-1:0]          out_alpha_nxt;
  dap_pkg::zone_t         fin_zone;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_alpha = out_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_fraction_r <= dap_pkg::RADIUS_FRACTION_RESET;
    end else if (cfg_wr_en) begin
      radius_fraction_r <= cfg_wr_data;
    end
  end

  dap_front #(
    .LOG2_MAX_SIZE  (LOG2_MAX_SIZE),
    .DIST_FRAC_BITS (F),
    .RAD_W          (RAD_W),
    .RADIUS_W       (RADIUS_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (adv),
    .in_valid        (in_valid),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_size_level   (in_size_level),
    .radius_fraction (radius_fraction_r),
    .valid_r         (fr_valid),
    .radicand_r      (fr_rad),
    .radius_r        (fr_radius)
  );

  assign sq_valid[0] = fr_valid;
  assign sq_rad[0]   = fr_rad;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = fr_radius;

  for (genvar g = 0; g < N_SQ; g++) begin : g_sqrt
    localparam int LEFT  = RW - g * SPS;
    localparam int STEPS = (LEFT < SPS) ? LEFT : SPS;
    dap_sqrt_stage #(
      .ROOT_W (RW),
      .STEPS  (STEPS),
      .SIDE_W (RADIUS_W)
    ) u_sq (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (sq_valid[g]),
      .in_rad   (sq_rad[g]),
      .in_rem   (sq_rem[g]),
      .in_root  (sq_root[g]),
      .in_side  (sq_side[g]),
      .valid_r  (sq_valid[g+1]),
      .rad_r    (sq_rad[g+1]),
      .rem_r    (sq_rem[g+1]),
      .root_r   (sq_root[g+1]),
      .side_r   (sq_side[g+1])
    );
  end

  always_comb begin
    logic [RW-1:0]   root_dist;
    logic [RW-1:0]   rad;
    logic [RW-1:0]   one;
    logic [RW-1:0]   diff;
    logic [RW+7:0]   prod;
    dap_pkg::zone_t  zone;
    root_dist = {1'b0, sq_root[N_SQ][RW-1:1]};
    rad  = RW'(sq_side[N_SQ]);
    one  = RW'(1) << F;
    diff = (root_dist < rad) ? (rad - root_dist) : '0;
    prod = ((RW+8)'(diff) << 8) - (RW+8)'(diff);
    if (rad < one) begin
      zone = (root_dist >= rad) ? dap_pkg::ZONE_OUT : dap_pkg::ZONE_SMALL;
    end else if (root_dist < rad - one) begin
      zone = dap_pkg::ZONE_FULL;
    end else if (root_dist < rad) begin
      zone = dap_pkg::ZONE_RIM;
    end else begin
      zone = dap_pkg::ZONE_OUT;
    end
    a_rem_nxt  = prod[F+7:8];
    a_low_nxt  = prod[7:0];
    a_dvs_nxt  = sq_side[N_SQ][F-1:0];
    a_side_nxt = {zone, prod[F+7:F]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= sq_valid[N_SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rem_r  <= a_rem_nxt;
      a_low_r  <= a_low_nxt;
      a_dvs_r  <= a_dvs_nxt;
      a_side_r <= a_side_nxt;
    end
  end

  assign dv_valid[0] = a_valid_r;
  assign dv_rem[0]   = a_rem_r;
  assign dv_low[0]   = a_low_r;
  assign dv_quot[0]  = '0;
  assign dv_dvs[0]   = a_dvs_r;
  assign dv_side[0]  = a_side_r;

  for (genvar d = 0; d < dap_pkg::DIV_STAGES; d++) begin : g_div
    dap_div_stage #(
      .DV_W   (F),
      .STEPS  (dap_pkg::DIV_STEPS),
      .SIDE_W (SIDE_W)
    ) u_dv (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (dv_valid[d]),
      .in_rem   (dv_rem[d]),
      .in_low   (dv_low[d]),
      .in_quot  (dv_quot[d]),
      .in_dvs   (dv_dvs[d]),
      .in_side  (dv_side[d]),
      .valid_r  (dv_valid[d+1]),
      .rem_r    (dv_rem[d+1]),
      .low_r    (dv_low[d+1]),
      .quot_r   (dv_quot[d+1]),
      .dvs_r    (dv_dvs[d+1]),
      .side_r   (dv_side[d+1])
    );
  end

  assign fin_zone = dap_pkg::zone_t'(dv_side[dap_pkg::DIV_STAGES][SIDE_W-1:AW]);

  always_comb begin
    case (fin_zone)
      dap_pkg::ZONE_FULL:  out_alpha_nxt = dap_pkg::ALPHA_FULL;
      dap_pkg::ZONE_RIM:   out_alpha_nxt = dv_side[dap_pkg::DIV_STAGES][AW-1:0];
      dap_pkg::ZONE_SMALL: out_alpha_nxt = dv_quot[dap_pkg::DIV_STAGES];
      default:             out_alpha_nxt = dap_pkg::ALPHA_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid[dap_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_alpha_r <= out_alpha_nxt;
    end
  end

endmodule

>>> rtl/dap_checker.sv
// Port checker for the disc alpha block, bound to the top level.
module dap_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_alpha
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_alpha))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind antialiased_disc_alpha dap_checker u_dap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_alpha (out_alpha)
);

>>> test/antialiased_disc_alpha_test.sv
// Testbench for antialiased_disc_alpha: random and directed pixels checked against a disc alpha predictor.
module antialiased_disc_alpha_test;

  localparam int MAX_LEVEL = 9;
  localparam int FRAC = 8;
  localparam int LATENCY = 10;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [8:0] x;
    logic [8:0] y;
    logic [3:0] level;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [8:0] in_pixel_x = '0;
  logic [8:0] in_pixel_y = '0;
  logic [3:0] in_size_level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [dap_pkg::ALPHA_W-1:0] out_alpha;
  logic cfg_wr_en = 1'b0;
  logic [dap_pkg::RF_W-1:0] cfg_wr_data = '0;

  antialiased_disc_alpha dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y), .in_size_level(in_size_level),
    .out_valid(out_valid), .out_stall(out_stall), .out_alpha(out_alpha),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pixel_t pending_pixels[$];
  logic [7:0] expected_alpha[$];
  logic [dap_pkg::RF_W-1:0] fraction_model = dap_pkg::RADIUS_FRACTION_RESET;
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_sender = 1'b0;
  bit hold_receiver = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [7:0] disc_alpha(pixel_t p, logic [dap_pkg::RF_W-1:0] frac);
    longint unsigned lvl, sz, px, py, dx, dy, dist_fx, rad, one, a;
    lvl = (p.level > MAX_LEVEL) ? MAX_LEVEL : p.level;
    sz = 64'd1 << lvl;
    px = p.x & (sz - 1);
    py = p.y & (sz - 1);
    dx = (2 * px + 1 >= sz) ? 2 * px + 1 - sz : sz - 2 * px - 1;
    dy = (2 * py + 1 >= sz) ? 2 * py + 1 - sz : sz - 2 * py - 1;
    dist_fx = root_floor((dx * dx + dy * dy) << (2 * FRAC)) >> 1;
    one = 64'd1 << FRAC;
    rad = ((sz * frac) >> (17 - FRAC)) + (64'd1 << (FRAC - 1));
    if (rad < one) a = (dist_fx >= rad) ? 0 : (255 * (rad - dist_fx)) / rad;
    else if (dist_fx < rad - one) a = 255;
    else if (dist_fx < rad) a = (255 * (rad - dist_fx)) >> FRAC;
    else a = 0;
    return a[7:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_alpha.push_back(disc_alpha({in_pixel_x, in_pixel_y, in_size_level},
                                          fraction_model));
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (hold_sender) begin
        in_valid <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        pixel_t p;
        p = pending_pixels.pop_front();
        in_valid <= 1'b1;
        in_pixel_x <= p.x;
        in_pixel_y <= p.y;
        in_size_level <= p.level;
        if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_alpha.size() == 0) begin
        $error("alpha: unexpected transfer, actual %0d", out_alpha);
        errors++;
      end else begin
        logic [7:0] e;
        e = expected_alpha.pop_front();
        if (e !== out_alpha) begin
          $error("alpha: expected %0d actual %0d", e, out_alpha);
          errors++;
        end
      end
    end
    if (hold_receiver) begin
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_pixel(int x, int y, int lvl);
    pixel_t p;
    p.x = 9'(x);
    p.y = 9'(y);
    p.level = 4'(lvl);
    pending_pixels.push_back(p);
  endtask

  task automatic add_random(int n);
    int lvl;
    repeat (n) begin
      lvl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) add_pixel($urandom_range(0, 511), $urandom_range(0, 511), lvl);
      else add_pixel($urandom_range(0, (1 << (lvl > 9 ? 9 : lvl)) - 1),
                     $urandom_range(0, (1 << (lvl > 9 ? 9 : lvl)) - 1), lvl);
    end
  endtask

  task automatic drain();
    while (pending_pixels.size() > 0 || in_valid || expected_alpha.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_fraction(logic [dap_pkg::RF_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fraction_model = v;
  endtask

  initial begin
    logic [dap_pkg::RF_W-1:0] settings[6];
    settings = '{16'd0, 16'd65535, 16'd1, 16'd32768, 16'd300, 16'd49151};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    add_pixel(0, 0, 0);
    add_pixel(511, 511, 9);
    add_pixel(255, 256, 9);
    add_pixel(256, 256, 9);
    add_pixel(0, 511, 15);
    add_pixel(300, 7, 12);
    add_pixel(7, 7, 3);
    add_pixel(3, 4, 3);
    add_pixel(0, 1, 1);
    add_pixel(511, 0, 2);
    add_pixel(1, 2, 2);
    add_pixel(170, 341, 8);
    add_pixel(15, 0, 4);
    add_random(120);
    drain();
    foreach (settings[i]) begin
      write_fraction(settings[i]);
      add_pixel(0, 0, 0);
      add_pixel(1, 1, 1);
      add_pixel(256, 256, 9);
      add_random(70);
      if (i == 2) begin
        hold_receiver = 1'b1;
        repeat (60) @(posedge clk);
        hold_receiver = 1'b0;
      end
      if (i == 3) begin
        while (pending_pixels.size() > 40) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_alpha.size() > 0 || in_valid) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end
    write_fraction(16'($urandom_range(0, 65535)));
    calm = 1'b1;
    add_random(120);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
